/* src/scp_pkg.sv */
package scp_pkg;

   localparam int DataW   = 32;
   localparam int CfgW    = 31;
   localparam int DtW     = 20;
   localparam int FracW   = 16;
   localparam int SqW     = 2 * DataW;
   localparam int RootW   = SqW / 2;
   localparam int QuotW   = CfgW;
   localparam int DvdW    = DataW + CfgW;
   localparam int DivW    = RootW;
   localparam int Lanes   = 3;
   localparam int CsrIdxW = 2;

   localparam logic [CfgW-1:0] TopSpeedReset = CfgW'(65536);
   localparam logic [CfgW-1:0] SlowDistReset = '0;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TOP_SPEED = 2'd0,
      CSR_SLOW_DIST = 2'd1,
      CSR_NO_REG    = 2'd3
   } csr_index_type;

   function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] x);
      return x[DataW-1] ? DataW'(-x) : x;
   endfunction

   function automatic logic [DataW-1:0] sat33(input logic [DataW:0] s);
      if (s[DataW] != s[DataW-1]) begin
         return s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
      return s[DataW-1:0];
   endfunction

   function automatic logic [DataW-1:0] sat40(input logic [39:0] s);
      if (s[39:DataW-1] != '0 && s[39:DataW-1] != '1) begin
         return s[39] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
      end
      return s[DataW-1:0];
   endfunction

endpackage

/* src/scp_if.sv */
interface scp_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [scp_pkg::DataW-1:0] target_x;
   logic signed [scp_pkg::DataW-1:0] target_y;
   logic signed [scp_pkg::DataW-1:0] target_z;
   logic signed [scp_pkg::DataW-1:0] pos_x;
   logic signed [scp_pkg::DataW-1:0] pos_y;
   logic signed [scp_pkg::DataW-1:0] pos_z;
   logic signed [scp_pkg::DataW-1:0] vel_x;
   logic signed [scp_pkg::DataW-1:0] vel_y;
   logic signed [scp_pkg::DataW-1:0] vel_z;
   logic        [scp_pkg::DtW-1:0]   time_step;

   modport source (output valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
                   vel_x, vel_y, vel_z, time_step, input ready);
   modport sink (input valid, target_x, target_y, target_z, pos_x, pos_y, pos_z,
                 vel_x, vel_y, vel_z, time_step, output ready);
endinterface

interface scp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [scp_pkg::DataW-1:0] new_vel_x;
   logic signed [scp_pkg::DataW-1:0] new_vel_y;
   logic signed [scp_pkg::DataW-1:0] new_vel_z;

   modport source (output valid, new_vel_x, new_vel_y, new_vel_z, input ready);
   modport sink (input valid, new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

/* src/scp_sqrt.sv */
module scp_sqrt #(
   parameter int SW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [scp_pkg::SqW-1:0]     in_val,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [scp_pkg::RootW-1:0]   out_root,
   output logic [SW-1:0]               out_side
);
   localparam int NS   = scp_pkg::RootW;
   localparam int RemW = scp_pkg::RootW + 2;

   logic [NS-1:0]              valid_ff;
   logic [scp_pkg::SqW-1:0]    val_ff  [NS];
   logic [RemW-1:0]            rem_ff  [NS];
   logic [scp_pkg::RootW-1:0]  root_ff [NS];
   logic [SW-1:0]              side_ff [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [scp_pkg::SqW-1:0]   val_p;
      logic [RemW-1:0]           rem_p;
      logic [scp_pkg::RootW-1:0] root_p;
      logic [SW-1:0]             side_p;
      logic                      vld_p;
      logic [RemW-1:0]           rem_sh;
      logic [RemW-1:0]           trial;
      logic                      take;
      logic [RemW-1:0]           rem_in;

      if (g == 0) begin : g_first
         assign val_p  = in_val;
         assign rem_p  = '0;
         assign root_p = '0;
         assign side_p = in_side;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign val_p  = val_ff[g-1];
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
         assign side_p = side_ff[g-1];
         assign vld_p  = valid_ff[g-1];
      end

      assign rem_sh = {rem_p[RemW-3:0], val_p[scp_pkg::SqW-1 -: 2]};
      assign trial  = {root_p, 2'b01};
      assign take   = rem_sh >= trial;
      assign rem_in = take ? rem_sh - trial : rem_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[g]  <= {val_p[scp_pkg::SqW-3:0], 2'b00};
            rem_ff[g]  <= rem_in;
            root_ff[g] <= {root_p[scp_pkg::RootW-2:0], take};
            side_ff[g] <= side_p;
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];
endmodule

/* src/scp_div.sv */
module scp_div #(
   parameter int SW = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [scp_pkg::DvdW-1:0]   in_dividend [scp_pkg::Lanes],
   input  logic [scp_pkg::DivW-1:0]   in_divisor,
   input  logic [SW-1:0]              in_side,
   output logic                       out_valid,
   output logic [scp_pkg::QuotW-1:0]  out_quot [scp_pkg::Lanes],
   output logic [SW-1:0]              out_side
);
   localparam int NS = scp_pkg::QuotW;
   localparam int L  = scp_pkg::Lanes;
   localparam int DW = scp_pkg::DivW;
   localparam int QW = scp_pkg::QuotW;

   logic [NS-1:0]   valid_ff;
   logic [DW-1:0]   div_ff  [NS];
   logic [SW-1:0]   side_ff [NS];
   logic [DW-1:0]   rem_ff  [NS][L];
   logic [QW-1:0]   lq_ff   [NS][L];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic [DW-1:0] div_p;
      logic [SW-1:0] side_p;
      logic          vld_p;

      if (g == 0) begin : g_first
         assign div_p  = in_divisor;
         assign side_p = in_side;
         assign vld_p  = in_valid;
      end else begin : g_next
         assign div_p  = div_ff[g-1];
         assign side_p = side_ff[g-1];
         assign vld_p  = valid_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[g]  <= div_p;
            side_ff[g] <= side_p;
         end
      end

      for (genvar l = 0; l < L; l++) begin : g_lane
         logic [DW-1:0] rem_p;
         logic [QW-1:0] lq_p;
         logic [DW:0]   rem2;
         logic [DW:0]   diff;
         logic          take;
         logic [DW-1:0] rem_in;
         logic [QW-1:0] lq_in;

         if (g == 0) begin : g_first
            assign rem_p = in_dividend[l][scp_pkg::DvdW-1:QW];
            assign lq_p  = in_dividend[l][QW-1:0];
         end else begin : g_next
            assign rem_p = rem_ff[g-1][l];
            assign lq_p  = lq_ff[g-1][l];
         end

         assign rem2   = {rem_p, lq_p[QW-1]};
         assign diff   = rem2 - {1'b0, div_p};
         assign take   = rem2 >= {1'b0, div_p};
         assign rem_in = take ? diff[DW-1:0] : rem2[DW-1:0];
         assign lq_in  = {lq_p[QW-2:0], take};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g][l] <= rem_in;
               lq_ff[g][l]  <= lq_in;
            end
         end
      end
   end

   for (genvar l = 0; l < L; l++) begin : g_out
      assign out_quot[l] = lq_ff[NS-1][l];
   end

   assign out_valid = valid_ff[NS-1];
   assign out_side  = side_ff[NS-1];
endmodule

/* src/seek_arrive_steering_step.sv */
// channel  | dir | handshake     | payload
// req      | in  | valid / ready | target, pos, vel (x y z), time_step
// rsp      | out | valid / ready | new_vel (x y z)
// csr      | in  | csr_write     | csr_index, csr_data
//
// one transfer per cycle in each direction while the output register is empty or being taken
// pipeline holds two 32-stage square roots and two 31-stage dividers
// synchronous reset clears valid bits and loads register defaults
// every stage advances when the output register is empty or being taken
module seek_arrive_steering_step (
   input  logic                          clock,
   input  logic                          reset,
   scp_req_if.sink                       req,
   scp_rsp_if.source                     rsp,
   input  logic                          csr_write,
   input  logic [scp_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [scp_pkg::CfgW-1:0]      csr_data
);
   localparam int DW  = scp_pkg::DataW;
   localparam int L   = scp_pkg::Lanes;
   localparam int S1W = L * DW + L + L * DW + scp_pkg::DtW;
   localparam int D1W = L + L * DW + scp_pkg::DtW;
   localparam int S2W = L * DW + L + L * DW;
   localparam int D2W = 1 + L + L * DW;

   logic [scp_pkg::CfgW-1:0] top_ff, slow_ff;
   logic en;
   logic out_valid_ff;
   logic [DW-1:0] out_vel_ff [L];

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= scp_pkg::TopSpeedReset;
         slow_ff <= scp_pkg::SlowDistReset;
      end else if (csr_write) begin
         case (scp_pkg::csr_index_type'(csr_index))
            scp_pkg::CSR_TOP_SPEED: top_ff  <= csr_data;
            scp_pkg::CSR_SLOW_DIST: slow_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;

   // stage a: offset
   logic                    a_valid_ff;
   logic [DW-1:0]           a_d_ff [L];
   logic [DW-1:0]           a_vel_ff [L];
   logic [scp_pkg::DtW-1:0] a_dt_ff;
   logic [DW-1:0]           tgt [L];
   logic [DW-1:0]           pos [L];
   logic [DW-1:0]           vin [L];

   assign tgt = '{req.target_x, req.target_y, req.target_z};
   assign pos = '{req.pos_x, req.pos_y, req.pos_z};
   assign vin = '{req.vel_x, req.vel_y, req.vel_z};

   // stage b: squares
   logic                    b_valid_ff;
   logic [DW-1:0]           b_mag_ff [L];
   logic [L-1:0]            b_neg_ff;
   logic [scp_pkg::SqW-1:0] b_sq_ff [L];
   logic [DW-1:0]           b_vel_ff [L];
   logic [scp_pkg::DtW-1:0] b_dt_ff;

   // stage c: sum
   logic                    c_valid_ff;
   logic [scp_pkg::SqW-1:0] c_sum_ff;
   logic [S1W-1:0]          c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            a_d_ff[i]   <= scp_pkg::sat33({tgt[i][DW-1], tgt[i]} - {pos[i][DW-1], pos[i]});
            a_vel_ff[i] <= vin[i];
            b_mag_ff[i] <= scp_pkg::mag32(a_d_ff[i]);
            b_neg_ff[i] <= a_d_ff[i][DW-1];
            b_sq_ff[i]  <= scp_pkg::mag32(a_d_ff[i]) * scp_pkg::mag32(a_d_ff[i]);
            b_vel_ff[i] <= a_vel_ff[i];
         end
         a_dt_ff   <= req.time_step;
         b_dt_ff   <= a_dt_ff;
         c_sum_ff  <= b_sq_ff[0] + b_sq_ff[1] + b_sq_ff[2];
         c_side_ff <= {b_mag_ff[0], b_mag_ff[1], b_mag_ff[2], b_neg_ff,
                       b_vel_ff[0], b_vel_ff[1], b_vel_ff[2], b_dt_ff};
      end
   end

   logic                      s1_valid;
   logic [scp_pkg::RootW-1:0] offset_len;
   logic [S1W-1:0]            s1_side;

   scp_sqrt #(.SW(S1W)) u_sqrt_dist (
      .clock, .reset, .en,
      .in_valid (c_valid_ff), .in_val (c_sum_ff), .in_side (c_side_ff),
      .out_valid(s1_valid), .out_root(offset_len), .out_side(s1_side)
   );

   // stage e: divisor select and scale by top speed
   logic [DW-1:0]             s1_mag [L];
   logic [scp_pkg::DivW-1:0]  e_div_in;
   logic                      e_valid_ff;
   logic [scp_pkg::DivW-1:0]  e_div_ff;
   logic [scp_pkg::DvdW-1:0]  e_dvd_ff [L];
   logic [D1W-1:0]            e_side_ff;

   assign s1_mag[0] = s1_side[S1W-1 -: DW];
   assign s1_mag[1] = s1_side[S1W-1-DW -: DW];
   assign s1_mag[2] = s1_side[S1W-1-2*DW -: DW];

   always_comb begin
      if (offset_len == '0) begin
         e_div_in = scp_pkg::DivW'(1);
      end else if (offset_len < {1'b0, slow_ff}) begin
         e_div_in = {1'b0, slow_ff};
      end else begin
         e_div_in = offset_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_div_ff  <= e_div_in;
         e_side_ff <= s1_side[D1W-1:0];
         for (int i = 0; i < L; i++) begin
            e_dvd_ff[i] <= s1_mag[i] * top_ff;
         end
      end
   end

   logic                      d1_valid;
   logic [scp_pkg::QuotW-1:0] des_q [L];
   logic [D1W-1:0]            d1_side;

   scp_div #(.SW(D1W)) u_div_desired (
      .clock, .reset, .en,
      .in_valid (e_valid_ff), .in_dividend (e_dvd_ff), .in_divisor (e_div_ff),
      .in_side (e_side_ff),
      .out_valid(d1_valid), .out_quot (des_q), .out_side (d1_side)
   );

   // stage f: steering difference, g: scale by dt, h: new velocity
   logic [L-1:0]            d1_neg;
   logic [DW-1:0]           d1_vel [L];
   logic [scp_pkg::DtW-1:0] d1_dt;
   logic [DW+1:0]           f_des [L];
   logic [DW+1:0]           f_diff [L];

   assign d1_neg    = d1_side[D1W-1 -: L];
   assign d1_vel[0] = d1_side[D1W-1-L -: DW];
   assign d1_vel[1] = d1_side[D1W-1-L-DW -: DW];
   assign d1_vel[2] = d1_side[D1W-1-L-2*DW -: DW];
   assign d1_dt     = d1_side[scp_pkg::DtW-1:0];

   for (genvar l = 0; l < L; l++) begin : g_diff
      assign f_des[l]  = d1_neg[l] ? (DW+2)'(-{3'b000, des_q[l]}) : {3'b000, des_q[l]};
      assign f_diff[l] = f_des[l] - {{2{d1_vel[l][DW-1]}}, d1_vel[l]};
   end

   localparam int PrW = DW + 1 + scp_pkg::DtW;

   logic                    f_valid_ff, g_valid_ff, h_valid_ff;
   logic [DW:0]             f_dmag_ff [L];
   logic [L-1:0]            f_dneg_ff;
   logic [DW-1:0]           f_vel_ff [L];
   logic [scp_pkg::DtW-1:0] f_dt_ff;
   logic [PrW-1:0]          g_prod_ff [L];
   logic [L-1:0]            g_dneg_ff;
   logic [DW-1:0]           g_vel_ff [L];
   logic [DW-1:0]           h_nv_ff [L];
   logic [39:0]             h_step [L];

   for (genvar l = 0; l < L; l++) begin : g_step
      assign h_step[l] = g_dneg_ff[l]
                         ? 40'(-{3'b000, g_prod_ff[l][PrW-1:scp_pkg::FracW]})
                         : {3'b000, g_prod_ff[l][PrW-1:scp_pkg::FracW]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= d1_valid;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_dt_ff <= d1_dt;
         for (int i = 0; i < L; i++) begin
            f_dmag_ff[i] <= f_diff[i][DW+1] ? (DW+1)'(-f_diff[i]) : f_diff[i][DW:0];
            f_dneg_ff[i] <= f_diff[i][DW+1];
            f_vel_ff[i]  <= d1_vel[i];
            g_prod_ff[i] <= f_dmag_ff[i] * f_dt_ff;
            g_dneg_ff[i] <= f_dneg_ff[i];
            g_vel_ff[i]  <= f_vel_ff[i];
            h_nv_ff[i]   <= scp_pkg::sat40({{8{g_vel_ff[i][DW-1]}}, g_vel_ff[i]} + h_step[i]);
         end
      end
   end

   // stage i: squares of new velocity, j: sum
   logic                    i_valid_ff, j_valid_ff;
   logic [DW-1:0]           i_mag_ff [L];
   logic [L-1:0]            i_neg_ff;
   logic [scp_pkg::SqW-1:0] i_sq_ff [L];
   logic [DW-1:0]           i_nv_ff [L];
   logic [scp_pkg::SqW-1:0] j_sum_ff;
   logic [S2W-1:0]          j_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
      end else if (en) begin
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < L; i++) begin
            i_mag_ff[i] <= scp_pkg::mag32(h_nv_ff[i]);
            i_neg_ff[i] <= h_nv_ff[i][DW-1];
            i_sq_ff[i]  <= scp_pkg::mag32(h_nv_ff[i]) * scp_pkg::mag32(h_nv_ff[i]);
            i_nv_ff[i]  <= h_nv_ff[i];
         end
         j_sum_ff  <= i_sq_ff[0] + i_sq_ff[1] + i_sq_ff[2];
         j_side_ff <= {i_mag_ff[0], i_mag_ff[1], i_mag_ff[2], i_neg_ff,
                       i_nv_ff[0], i_nv_ff[1], i_nv_ff[2]};
      end
   end

   logic                      s2_valid;
   logic [scp_pkg::RootW-1:0] len;
   logic [S2W-1:0]            s2_side;

   scp_sqrt #(.SW(S2W)) u_sqrt_len (
      .clock, .reset, .en,
      .in_valid (j_valid_ff), .in_val (j_sum_ff), .in_side (j_side_ff),
      .out_valid(s2_valid), .out_root(len), .out_side(s2_side)
   );

   // stage k: speed clamp setup
   logic [DW-1:0]             s2_mag [L];
   logic                      k_clamp_in;
   logic                      k_valid_ff;
   logic [scp_pkg::DivW-1:0]  k_div_ff;
   logic [scp_pkg::DvdW-1:0]  k_dvd_ff [L];
   logic [D2W-1:0]            k_side_ff;

   assign s2_mag[0]  = s2_side[S2W-1 -: DW];
   assign s2_mag[1]  = s2_side[S2W-1-DW -: DW];
   assign s2_mag[2]  = s2_side[S2W-1-2*DW -: DW];
   assign k_clamp_in = len > {1'b0, top_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (en) begin
         k_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_div_ff  <= k_clamp_in ? len : scp_pkg::DivW'(1);
         k_side_ff <= {k_clamp_in, s2_side[D2W-2:0]};
         for (int i = 0; i < L; i++) begin
            k_dvd_ff[i] <= s2_mag[i] * top_ff;
         end
      end
   end

   logic                      d2_valid;
   logic [scp_pkg::QuotW-1:0] clamp_q [L];
   logic [D2W-1:0]            d2_side;

   scp_div #(.SW(D2W)) u_div_clamp (
      .clock, .reset, .en,
      .in_valid (k_valid_ff), .in_dividend (k_dvd_ff), .in_divisor (k_div_ff),
      .in_side (k_side_ff),
      .out_valid(d2_valid), .out_quot (clamp_q), .out_side (d2_side)
   );

   // output register
   logic          d2_clamp;
   logic [L-1:0]  d2_neg;
   logic [DW-1:0] d2_nv [L];
   logic [DW-1:0] out_vel_in [L];

   assign d2_clamp = d2_side[D2W-1];
   assign d2_neg   = d2_side[D2W-2 -: L];
   assign d2_nv[0] = d2_side[D2W-2-L -: DW];
   assign d2_nv[1] = d2_side[D2W-2-L-DW -: DW];
   assign d2_nv[2] = d2_side[D2W-2-L-2*DW -: DW];

   for (genvar l = 0; l < L; l++) begin : g_res
      assign out_vel_in[l] = !d2_clamp ? d2_nv[l]
                           : d2_neg[l] ? DW'(-{1'b0, clamp_q[l]}) : {1'b0, clamp_q[l]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vel_ff <= out_vel_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.new_vel_x = out_vel_ff[0];
   assign rsp.new_vel_y = out_vel_ff[1];
   assign rsp.new_vel_z = out_vel_ff[2];
endmodule

/* src/scp_chk.sv */
module scp_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [scp_pkg::DataW-1:0] rsp_x,
   input logic [scp_pkg::DataW-1:0] rsp_y,
   input logic [scp_pkg::DataW-1:0] rsp_z
);
   // result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_z))
      else $error("rsp payload changed while stalled");

   // an empty output register never blocks the input
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req stalled while rsp drains");

   a_reset_empty: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp valid right after reset");
endmodule

bind seek_arrive_steering_step scp_chk u_scp_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_x     (rsp.new_vel_x),
   .rsp_y     (rsp.new_vel_y),
   .rsp_z     (rsp.new_vel_z)
);
